### design/qsu_pkg.sv
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants for the quoted string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

   localparam int unsigned MAX_CAPACITY    = 256;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam logic [8:0]  CAP_RESET       = 9'd128;

   localparam logic [1:0] ST_DATA = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   typedef struct packed {
      logic [1:0]      status;
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
   } qsu_entry_type;

endpackage

`default_nettype wire

### design/qsu_front.sv
// ----------------------------------------------------------------------------
// qsu_front
// Parser: accepts string bytes, tracks escape state, builds result groups.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_front
   import qsu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [8:0]    csr_out_capacity,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   input  wire logic          start_req,
   output qsu_entry_type      ent,
   output logic               ent_valid
);

   localparam logic [8:0] CAP_LIMIT = (MAX_CAPACITY > 256) ? 9'd256 : 9'(MAX_CAPACITY);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_LU    = 8'h75;
   localparam logic [7:0] CH_UU    = 8'h55;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_BODY = 4'b0010,
      MODE_ESC  = 4'b0100,
      MODE_HEX  = 4'b1000
   } qsu_mode_type;

   qsu_mode_type mode_ff, mode_in;
   logic [3:0]   hex_left_ff, hex_left_in;
   logic [31:0]  code_acc_ff, code_acc_in;
   logic [7:0]   byte_count_ff, byte_count_in;
   logic [8:0]   cap_ff, cap_in;

   logic [8:0]      eff_cap;
   logic            do_fail, do_emit;
   logic [2:0]      cnt;
   logic [3:0][7:0] grp;
   logic [8:0]      sum;
   logic            hex_ok;
   logic [3:0]      nibble;
   logic [31:0]     acc_next;
   logic [3:0]      hl_next;
   logic [20:0]     cp;

   assign eff_cap = (cap_ff > CAP_LIMIT) ? CAP_LIMIT : cap_ff;
   assign cap_in  = csr_we ? csr_out_capacity : cap_ff;

   always_comb begin
      hex_ok = 1'b1;
      nibble = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         nibble = in_byte[3:0];
      end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         nibble = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_next = {code_acc_ff[27:0], nibble};
   assign hl_next  = hex_left_ff - 4'd1;
   assign cp       = acc_next[20:0];

   always_comb begin
      mode_in       = mode_ff;
      hex_left_in   = hex_left_ff;
      code_acc_in   = code_acc_ff;
      byte_count_in = byte_count_ff;
      ent           = '0;
      ent_valid     = 1'b0;
      do_fail       = 1'b0;
      do_emit       = 1'b0;
      cnt           = 3'd1;
      grp           = '0;
      sum           = '0;

      if (accept) begin
         if (start_req) begin
            byte_count_in = '0;
            hex_left_in   = '0;
            code_acc_in   = '0;
            if (in_byte != CH_QUOTE) begin
               do_fail = 1'b1;
            end else begin
               mode_in = MODE_BODY;
            end
         end else begin
            case (mode_ff)
               MODE_BODY: begin
                  if (in_byte == 8'h00) begin
                     do_fail = 1'b1;
                  end else if (in_byte == CH_QUOTE) begin
                     mode_in       = MODE_IDLE;
                     ent_valid     = 1'b1;
                     ent.status    = ST_DONE;
                     ent.bytes[0]  = byte_count_ff;
                  end else if (in_byte == CH_BSL) begin
                     mode_in = MODE_ESC;
                  end else begin
                     grp[0]  = in_byte;
                     do_emit = 1'b1;
                  end
               end
               MODE_ESC: begin
                  mode_in = MODE_BODY;
                  case (in_byte)
                     CH_LU: begin
                        mode_in     = MODE_HEX;
                        hex_left_in = 4'd4;
                        code_acc_in = '0;
                     end
                     CH_UU: begin
                        mode_in     = MODE_HEX;
                        hex_left_in = 4'd8;
                        code_acc_in = '0;
                     end
                     CH_N: begin
                        grp[0]  = 8'h0a;
                        do_emit = 1'b1;
                     end
                     CH_R: begin
                        grp[0]  = 8'h0d;
                        do_emit = 1'b1;
                     end
                     CH_T: begin
                        grp[0]  = 8'h09;
                        do_emit = 1'b1;
                     end
                     CH_BSL, CH_QUOTE: begin
                        grp[0]  = in_byte;
                        do_emit = 1'b1;
                     end
                     default: begin
                        do_fail = 1'b1;
                     end
                  endcase
               end
               MODE_HEX: begin
                  if (!hex_ok) begin
                     do_fail = 1'b1;
                  end else if (hl_next != 4'd0) begin
                     code_acc_in = acc_next;
                     hex_left_in = hl_next;
                  end else begin
                     code_acc_in = '0;
                     hex_left_in = '0;
                     mode_in     = MODE_BODY;
                     if (acc_next > 32'h0010ffff) begin
                        do_fail = 1'b1;
                     end else if (acc_next <= 32'h0000007f) begin
                        grp[0] = {1'b0, cp[6:0]};
                        cnt    = 3'd1;
                        do_emit = 1'b1;
                     end else if (acc_next <= 32'h000007ff) begin
                        grp[0] = {3'b110, cp[10:6]};
                        grp[1] = {2'b10, cp[5:0]};
                        cnt    = 3'd2;
                        do_emit = 1'b1;
                     end else if (acc_next <= 32'h0000ffff) begin
                        grp[0] = {4'b1110, cp[15:12]};
                        grp[1] = {2'b10, cp[11:6]};
                        grp[2] = {2'b10, cp[5:0]};
                        cnt    = 3'd3;
                        do_emit = 1'b1;
                     end else begin
                        grp[0] = {5'b11110, cp[20:18]};
                        grp[1] = {2'b10, cp[17:12]};
                        grp[2] = {2'b10, cp[11:6]};
                        grp[3] = {2'b10, cp[5:0]};
                        cnt    = 3'd4;
                        do_emit = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (do_emit) begin
            sum = {1'b0, byte_count_ff} + {6'd0, cnt};
            if (sum >= eff_cap) begin
               do_fail = 1'b1;
            end else begin
               ent_valid     = 1'b1;
               ent.status    = ST_DATA;
               ent.last_idx  = 2'(cnt - 3'd1);
               ent.bytes     = grp;
               byte_count_in = sum[7:0];
            end
         end

         if (do_fail) begin
            mode_in     = MODE_IDLE;
            hex_left_in = '0;
            code_acc_in = '0;
            ent_valid   = 1'b1;
            ent         = '0;
            ent.status  = ST_ERR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         hex_left_ff   <= '0;
         code_acc_ff   <= '0;
         byte_count_ff <= '0;
         cap_ff        <= CAP_RESET;
      end else begin
         mode_ff       <= mode_in;
         hex_left_ff   <= hex_left_in;
         code_acc_ff   <= code_acc_in;
         byte_count_ff <= byte_count_in;
         cap_ff        <= cap_in;
      end
   end

endmodule

`default_nettype wire

### design/qsu_queue.sv
// ----------------------------------------------------------------------------
// qsu_queue
// Short queue of result groups between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_queue
   import qsu_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire qsu_entry_type              push_ent,
   input  wire logic                       pop,
   output qsu_entry_type                   head,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   qsu_entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/qsu_back.sv
// ----------------------------------------------------------------------------
// qsu_back
// Output sequencer: presents each queued group one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_back
   import qsu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire qsu_entry_type head,
   input  wire logic          head_valid,
   input  wire logic          rsp_pop,
   output logic               q_pop,
   output logic               rsp_empty,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_out_length,
   output logic               rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign rsp_empty      = !head_valid;
   assign rsp_status     = head.status;
   assign rsp_last       = (idx_ff == head.last_idx);
   assign rsp_out_byte   = (head.status == ST_DATA) ? head.bytes[idx_ff] : 8'd0;
   assign rsp_out_length = (head.status == ST_DONE) ? head.bytes[0] : 8'd0;

   assign take  = rsp_pop && head_valid;
   assign q_pop = take && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = rsp_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

### design/quoted_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8_core
// Quoted string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// The block takes one string byte per cycle whenever full is low. Each
// byte is parsed in the cycle it is taken, and any results it causes go as one
// group into a QUEUE_DEPTH-entry queue. The output side presents one result per
// cycle while pop is high, so a byte giving one result keeps the stream at one
// byte per cycle; a \u or \U escape whose code point encodes to N UTF-8 bytes
// gives N results from one entry, and full rises once the queue fills behind it.
// Results reach the rsp_ ports in the cycle after the causing byte at best.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescape_utf8_core
   import qsu_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [8:0]    csr_out_capacity,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          req_start_req,
   output logic               empty,
   input  wire logic          pop,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_out_length,
   output logic               rsp_last
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   qsu_entry_type    ent, head;
   logic             ent_valid;
   logic             accept;
   logic             q_pop;
   logic [CNT_W-1:0] q_count;

   assign full   = (q_count == CNT_W'(QUEUE_DEPTH));
   assign accept = push && !full;

   qsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_out_capacity (csr_out_capacity),
      .accept           (accept),
      .in_byte          (req_in_byte),
      .start_req        (req_start_req),
      .ent              (ent),
      .ent_valid        (ent_valid)
   );

   qsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (ent_valid),
      .push_ent (ent),
      .pop      (q_pop),
      .head     (head),
      .count    (q_count)
   );

   qsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (q_count != '0),
      .rsp_pop        (pop),
      .q_pop          (q_pop),
      .rsp_empty      (empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_out_length (rsp_out_length),
      .rsp_last       (rsp_last)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status == ST_DONE || rsp_status == ST_ERR)) |-> rsp_last)
      else $error("completion or error result not marked last");

   a_group_holds: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last) |=> !empty)
      else $error("group cut short");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (full && !$past(q_pop)) |-> !ent_valid)
      else $error("queue written while full");

endmodule

`default_nettype wire
